// ----- design/ipxc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipxc_pkg: shared constants and helpers for the image permute and xor-chain cipher
// Holds sizes, command and register codes, and the key stream helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ipxc_pkg;

    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int PIX_W      = 24;
    localparam int WORD_W     = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SEED  = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [WORD_W-1:0] xs32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    // word bytes 1, 2, 3 go to r, g, b
    function automatic logic [PIX_W-1:0] word_mask(input logic [WORD_W-1:0] w);
        return {w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

// ----- design/image_permute_xor_chain_cipher.sv -----
// ----------------------------------------------------------------------------
// image_permute_xor_chain_cipher: permutation plus xor-chain image cipher
// Pixel, result, permutation and key stores in synchronous memories.
// ----------------------------------------------------------------------------
// A pixel write transfer is taken every cycle while the block is idle, no read
// is pending and the output is not held; a read transfer passes through one
// memory read and then the output register, and no transfer is taken while its
// read is pending. A run of N pixels walks the memories: the key stream, then
// N-1 shuffle steps (a bit-serial remainder of the 32-bit key word plus perm
// table reads and the two swap writes), then scatter and chain for encrypt or
// chain and gather for decrypt. The run answers with one result, pixel zero
// and done set; reads return zero with done clear until a run has completed.
`default_nettype none

module image_permute_xor_chain_cipher
    import ipxc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd[1:0], pixel_index[13:2], pixel_in[37:14]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pixel_out[23:0], done_res[24]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_GEN, ST_SH_RD, ST_SH_LD, ST_SH_DIV, ST_SH_PRD, ST_SH_SW1,
        ST_SH_SW2, ST_SH_END, ST_SCAT, ST_CHAIN, ST_DCHAIN, ST_GATH, ST_FIN
    } state_t;

    // configuration
    logic               mode_reg;
    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  sv_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            seed_reg  <= 32'd1;
            sv_reg    <= '0;
            count_reg <= COUNT_W'(MAX_PIXELS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_wdata[0];
                REG_SEED:  seed_reg  <= cfg_wdata;
                REG_START: sv_reg    <= cfg_wdata;
                REG_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [COUNT_W-1:0] n_eff;
    always_comb
    begin
        if (count_reg == '0)
            n_eff = COUNT_W'(1);
        else if (count_reg > COUNT_W'(MAX_PIXELS))
            n_eff = COUNT_W'(MAX_PIXELS);
        else
            n_eff = count_reg;
    end

    // input fields
    logic [1:0]        in_cmd;
    logic [ADDR_W-1:0] in_idx;
    logic [PIX_W-1:0]  in_pix;
    assign in_cmd = s_tdata[1:0];
    assign in_idx = s_tdata[13:2];
    assign in_pix = s_tdata[37:14];

    // memories
    logic [PIX_W-1:0]  pix_mem  [MAX_PIXELS];
    logic [PIX_W-1:0]  res_mem  [MAX_PIXELS];
    logic [ADDR_W-1:0] perm_mem [MAX_PIXELS];
    logic [WORD_W-1:0] rnd_mem  [MAX_PIXELS];

    logic              pix_we,  res_we,  perm_we,  rnd_we;
    logic [ADDR_W-1:0] pix_waddr, res_waddr, perm_waddr, rnd_waddr;
    logic [PIX_W-1:0]  pix_wdata, res_wdata;
    logic [ADDR_W-1:0] perm_wdata;
    logic [WORD_W-1:0] rnd_wdata;
    logic [ADDR_W-1:0] pix_raddr, res_raddr, perm_raddr_a, perm_raddr_b, rnd_raddr;
    logic [PIX_W-1:0]  pix_rdata, res_rdata;
    logic [ADDR_W-1:0] perm_rdata_a, perm_rdata_b;
    logic [WORD_W-1:0] rnd_rdata;

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        pix_rdata <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_waddr] <= res_wdata;
        res_rdata <= res_mem[res_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        perm_rdata_a <= perm_mem[perm_raddr_a];
        perm_rdata_b <= perm_mem[perm_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (rnd_we)
            rnd_mem[rnd_waddr] <= rnd_wdata;
        rnd_rdata <= rnd_mem[rnd_raddr];
    end

    // control registers
    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [WORD_W-1:0]  x_reg, x_next;
    logic [WORD_W-1:0]  rn_reg, rn_next;
    logic [WORD_W-1:0]  q_reg, q_next;
    logic [ADDR_W:0]    rem_reg, rem_next;
    logic [4:0]         bit_reg, bit_next;
    logic [ADDR_W-1:0]  pa_reg, pa_next;
    logic [PIX_W-1:0]   prev_reg, prev_next;
    logic               s1_vld_reg, s1_vld_next, s2_vld_reg, s2_vld_next;
    logic [ADDR_W-1:0]  s1_idx_reg, s1_idx_next, s2_idx_reg, s2_idx_next;
    logic               rvalid_reg, rvalid_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_pix_reg, out_pix_next;
    logic               out_done_reg, out_done_next;
    // pa_valid marks a pending second swap write
    logic               pa_valid_reg, pa_valid_next;

    logic               in_xfer;
    logic               issue;
    logic [WORD_W-1:0]  x_gen;
    logic [ADDR_W+1:0]  div_t;
    logic [ADDR_W+1:0]  div_d;
    logic [WORD_W-1:0]  key;
    logic [PIX_W-1:0]   chain_val;

    assign s_tready = (state_reg == ST_IDLE) && !pend_reg && (!out_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign issue    = cnt_reg < n_eff;
    assign x_gen    = xs32(x_reg);
    assign div_t    = {rem_reg, q_reg[WORD_W-1]};
    assign div_d    = (ADDR_W+2)'(i_reg) + (ADDR_W+2)'(1);
    assign key      = (s1_idx_reg == '0) ? (sv_reg ^ rn_reg) : x_gen;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_done_reg, out_pix_reg};

    // read addresses
    assign pix_raddr    = cnt_reg[ADDR_W-1:0];
    assign res_raddr    = (state_reg == ST_IDLE) ? in_idx : cnt_reg[ADDR_W-1:0];
    assign perm_raddr_a = (state_reg == ST_SH_PRD || state_reg == ST_SH_SW1)
                          ? i_reg[ADDR_W-1:0] : cnt_reg[ADDR_W-1:0];
    assign perm_raddr_b = j_reg;
    assign rnd_raddr    = (state_reg == ST_GATH) ? perm_rdata_a : i_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        rn_next        = rn_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        pa_next        = pa_reg;
        prev_next      = prev_reg;
        s1_vld_next    = 1'b0;
        s1_idx_next    = s1_idx_reg;
        s2_vld_next    = 1'b0;
        s2_idx_next    = s2_idx_reg;
        rvalid_next    = rvalid_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_pix_next   = out_pix_reg;
        out_done_next  = out_done_reg;
        chain_val      = prev_reg ^ res_rdata ^ word_mask(key);

        pix_we = 1'b0;  pix_waddr  = in_idx;                pix_wdata = in_pix;
        res_we = 1'b0;  res_waddr  = s1_idx_reg;            res_wdata = chain_val;
        perm_we = 1'b0; perm_waddr = cnt_reg[ADDR_W-1:0];   perm_wdata = cnt_reg[ADDR_W-1:0];
        rnd_we = 1'b0;  rnd_waddr  = cnt_reg[ADDR_W-1:0];   rnd_wdata = x_gen;

        // read response loaded in the cycle after the transfer
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = rvalid_reg ? res_rdata : '0;
            out_done_next  = rvalid_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_cmd)
                        CMD_WRITE: pix_we = 1'b1;
                        CMD_READ:  pend_next = 1'b1;
                        CMD_RUN:
                        begin
                            state_next = ST_GEN;
                            cnt_next   = '0;
                            x_next     = seed_reg;
                            prev_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_GEN:
            begin
                rnd_we  = 1'b1;
                perm_we = 1'b1;
                x_next  = x_gen;
                if (cnt_reg == n_eff - COUNT_W'(1))
                begin
                    rn_next  = x_gen;
                    i_next   = n_eff - COUNT_W'(1);
                    cnt_next = '0;
                    if (n_eff == COUNT_W'(1))
                        state_next = mode_reg ? ST_DCHAIN : ST_SCAT;
                    else
                        state_next = ST_SH_RD;
                end
                else
                    cnt_next = cnt_reg + COUNT_W'(1);
            end
            ST_SH_RD:
                state_next = ST_SH_LD;
            ST_SH_LD:
            begin
                q_next     = rnd_rdata;
                rem_next   = '0;
                bit_next   = '0;
                state_next = ST_SH_DIV;
            end
            ST_SH_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (div_t >= div_d)
                    rem_next = (ADDR_W+1)'(div_t - div_d);
                else
                    rem_next = div_t[ADDR_W:0];
                q_next   = q_reg << 1;
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                    state_next = ST_SH_PRD;
            end
            ST_SH_PRD:
            begin
                j_next     = rem_reg[ADDR_W-1:0];
                state_next = ST_SH_SW1;
            end
            ST_SH_SW1:
            begin
                // j_reg was loaded in ST_SH_PRD so port b reads perm[j] here
                state_next = ST_SH_SW2;
            end
            ST_SH_SW2:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg[ADDR_W-1:0];
                perm_wdata = perm_rdata_b;
                pa_next    = perm_rdata_a;
                state_next = ST_SH_RD;
                i_next     = i_reg - COUNT_W'(1);
                // the second swap write goes out in the next state step
            end
            ST_SH_END:
                state_next = mode_reg ? ST_DCHAIN : ST_SCAT;
            ST_SCAT:
            begin
                if (issue)
                begin
                    cnt_next    = cnt_reg + COUNT_W'(1);
                    s1_vld_next = 1'b1;
                end
                if (s1_vld_reg)
                begin
                    res_we    = 1'b1;
                    res_waddr = perm_rdata_a;
                    res_wdata = pix_rdata;
                end
                if (!issue && !s1_vld_reg)
                begin
                    state_next = ST_CHAIN;
                    cnt_next   = '0;
                    prev_next  = '0;
                end
            end
            ST_CHAIN:
            begin
                if (issue)
                begin
                    cnt_next    = cnt_reg + COUNT_W'(1);
                    s1_vld_next = 1'b1;
                    s1_idx_next = cnt_reg[ADDR_W-1:0];
                end
                if (s1_vld_reg)
                begin
                    res_we    = 1'b1;
                    prev_next = chain_val;
                    if (s1_idx_reg != '0)
                        x_next = x_gen;
                end
                if (!issue && !s1_vld_reg)
                    state_next = ST_FIN;
            end
            ST_DCHAIN:
            begin
                chain_val = prev_reg ^ pix_rdata ^ word_mask(key);
                if (issue)
                begin
                    cnt_next    = cnt_reg + COUNT_W'(1);
                    s1_vld_next = 1'b1;
                    s1_idx_next = cnt_reg[ADDR_W-1:0];
                end
                if (s1_vld_reg)
                begin
                    rnd_we    = 1'b1;
                    rnd_waddr = s1_idx_reg;
                    rnd_wdata = WORD_W'(chain_val);
                    prev_next = pix_rdata;
                    if (s1_idx_reg != '0)
                        x_next = x_gen;
                end
                if (!issue && !s1_vld_reg)
                begin
                    state_next = ST_GATH;
                    cnt_next   = '0;
                end
            end
            ST_GATH:
            begin
                if (issue)
                begin
                    cnt_next    = cnt_reg + COUNT_W'(1);
                    s1_vld_next = 1'b1;
                    s1_idx_next = cnt_reg[ADDR_W-1:0];
                end
                s2_vld_next = s1_vld_reg;
                s2_idx_next = s1_idx_reg;
                if (s2_vld_reg)
                begin
                    res_we    = 1'b1;
                    res_waddr = s2_idx_reg;
                    res_wdata = rnd_rdata[PIX_W-1:0];
                end
                if (!issue && !s1_vld_reg && !s2_vld_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                rvalid_next    = 1'b1;
                out_valid_next = 1'b1;
                out_pix_next   = '0;
                out_done_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // second swap write: perm[j] takes the old perm[i]
        if ((state_reg == ST_SH_RD || state_reg == ST_SH_END) && pa_valid_reg)
        begin
            perm_we    = 1'b1;
            perm_waddr = j_reg;
            perm_wdata = pa_reg;
        end
        if (state_reg == ST_SH_SW2 && i_reg == COUNT_W'(1))
            state_next = ST_SH_END;
    end

    always_comb
    begin
        pa_valid_next = (state_reg == ST_SH_SW2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            bit_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            rvalid_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pa_valid_reg  <= 1'b0;
            x_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            bit_reg       <= bit_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
            rvalid_reg    <= rvalid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            pa_valid_reg  <= pa_valid_next;
            x_reg         <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        rn_reg       <= rn_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        pa_reg       <= pa_next;
        prev_reg     <= prev_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        out_pix_reg  <= out_pix_next;
        out_done_reg <= out_done_next;
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: image_permute_xor_chain_cipher stream-level check
// Loads images, runs encrypt and decrypt under many keys and sizes, reads the
// results back and compares every reply against an in-bench model of the
// shuffle and xor chain, with random idling and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipxc_pkg::*;

    // command code the block ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] idx;
        logic [23:0] pix;
    } pixel_cmd_t;

    typedef struct packed {
        logic [23:0] pixel;
        logic        done;
    } pixel_reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // cmd[1:0], pixel_index[13:2], pixel_in[37:14]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pixel_out[23:0], done_res[24]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    image_permute_xor_chain_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // model state
    logic        mdl_decrypt;
    logic [31:0] mdl_seed;
    logic [31:0] mdl_start;
    logic [12:0] mdl_count;
    logic [23:0] pix_mem [MAX_PIXELS];
    logic [23:0] res_mem [MAX_PIXELS];
    logic [23:0] scratch [MAX_PIXELS];
    logic [31:0] key_words [MAX_PIXELS];
    int          order_map [MAX_PIXELS];
    logic        results_ready;

    // stimulus side bookkeeping
    bit          gen_done [MAX_PIXELS];
    pixel_cmd_t  cmd_queue [$];
    pixel_reply_t reply_queue [$];
    pixel_cmd_t  offered;
    bit          send_hold;
    bit          hold_req;
    bit          hold_taken;
    int          hold_left;
    int          cyc;
    int          fails;
    int          stim_count;
    logic        calm;

    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        return y ^ (y << 5);
    endfunction

    // key bytes 1, 2, 3 land on r, g, b
    function automatic logic [23:0] rgb_key(input logic [31:0] w);
        return {w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic int clamp_count(input logic [12:0] c);
        if (c == '0)
            return 1;
        if (c > 13'(MAX_PIXELS))
            return MAX_PIXELS;
        return int'(c);
    endfunction

    task automatic cipher_run();
        int          n;
        int          i;
        int          j;
        int          t;
        logic [31:0] x;
        n = clamp_count(mdl_count);
        x = mdl_seed;
        for (i = 0; i < n; i++)
        begin
            x = xorshift_step(x);
            key_words[i] = x;
        end
        for (i = 0; i < n; i++)
            order_map[i] = i;
        for (i = n - 1; i > 0; i--)
        begin
            j = int'(key_words[i] % 32'(i + 1));
            t = order_map[i];
            order_map[i] = order_map[j];
            order_map[j] = t;
        end
        if (!mdl_decrypt)
        begin
            for (i = 0; i < n; i++)
                res_mem[order_map[i]] = pix_mem[i];
            res_mem[0] = res_mem[0] ^ rgb_key(mdl_start ^ key_words[n-1]);
            for (i = 1; i < n; i++)
            begin
                x = xorshift_step(x);
                res_mem[i] = res_mem[i-1] ^ res_mem[i] ^ rgb_key(x);
            end
        end
        else
        begin
            scratch[0] = pix_mem[0] ^ rgb_key(mdl_start ^ key_words[n-1]);
            for (i = 1; i < n; i++)
            begin
                x = xorshift_step(x);
                scratch[i] = pix_mem[i-1] ^ pix_mem[i] ^ rgb_key(x);
            end
            for (i = 0; i < n; i++)
                res_mem[i] = scratch[order_map[i]];
        end
        results_ready = 1'b1;
    endtask

    task automatic predict_transfer(input pixel_cmd_t c);
        pixel_reply_t r;
        case (c.op)
            CMD_WRITE: pix_mem[c.idx] = c.pix;
            CMD_RUN:
            begin
                cipher_run();
                r.pixel = '0;
                r.done  = 1'b1;
                reply_queue.push_back(r);
            end
            CMD_READ:
            begin
                r.pixel = results_ready ? res_mem[c.idx] : 24'h0;
                r.done  = results_ready;
                reply_queue.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fails++;
    endtask

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc <= 0;
        else
            cyc <= cyc + 1;
    end

    assign calm = (cyc >= 12000 && cyc < 20000);

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_transfer(offered);
            if (!s_tvalid || s_tready)
            begin
                if (cmd_queue.size() > 0 && !send_hold && (calm || $urandom_range(0, 99) >= 28))
                begin
                    offered = cmd_queue.pop_front();
                    s_tdata  <= {2'b00, offered.pix, offered.idx, offered.op};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= 700;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 28);
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_queue.size() == 0)
                report("unexpected transfer", m_tdata[23:0], 24'h0);
            else
            begin
                want = reply_queue.pop_front();
                if (m_tdata[23:0] !== want.pixel)
                    report("pixel_out", m_tdata[23:0], want.pixel);
                if (m_tdata[24] !== want.done)
                    report("done_res", {23'h0, m_tdata[24]}, {23'h0, want.done});
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic [11:0] idx, input logic [23:0] pix);
        pixel_cmd_t c;
        c.op  = op;
        c.idx = idx;
        c.pix = pix;
        cmd_queue.push_back(c);
        if (op != CMD_NONE)
            stim_count++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || s_tvalid || reply_queue.size() != 0);
        // writes give no reply, let the last ones settle
        repeat (50) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MODE:  mdl_decrypt = val[0];
            REG_SEED:  mdl_seed    = val;
            REG_START: mdl_start   = val;
            REG_COUNT: mdl_count   = val[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic mode, input logic [31:0] seed, input logic [31:0] sv,
                             input logic [12:0] count);
        wait_idle();
        cfg_write(REG_MODE, {31'h0, mode});
        cfg_write(REG_SEED, seed);
        cfg_write(REG_START, sv);
        cfg_write(REG_COUNT, {19'h0, count});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_run(input logic [12:0] count);
        int i;
        push_cmd(CMD_RUN, 12'($urandom), 24'($urandom));
        for (i = 0; i < clamp_count(count); i++)
            gen_done[i] = 1'b1;
    endtask

    function automatic logic [11:0] read_index(input int n);
        logic [11:0] idx;
        idx = 12'($urandom);
        if (!gen_done[idx])
            idx = 12'($urandom_range(0, n - 1));
        return idx;
    endfunction

    // load a full image, transform it, read back with some noise mixed in
    task automatic image_pass(input logic mode, input logic [31:0] seed, input logic [31:0] sv,
                              input logic [12:0] count, input int reads, input bit stall_out);
        int n;
        int i;
        int k;
        n = clamp_count(count);
        configure(mode, seed, sv, count);
        for (i = 0; i < n; i++)
            push_cmd(CMD_WRITE, 12'(i), 24'($urandom));
        repeat ($urandom_range(0, 3))
            push_cmd(CMD_WRITE, 12'($urandom), 24'($urandom));
        push_run(count);
        for (i = 0; i < reads; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 80)
                push_cmd(CMD_READ, read_index(n), 24'($urandom));
            else if (k < 90)
                push_cmd(CMD_WRITE, 12'($urandom), 24'($urandom));
            else if (k < 95)
                push_cmd(CMD_NONE, 12'($urandom), 24'($urandom));
            else
                push_run(count);
        end
        if (stall_out)
            hold_req = 1'b1;
    endtask

    function automatic logic [31:0] key_value();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'h0;
        if (k == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    initial
    begin
        logic [12:0] count;
        int          k;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MODE;
        cfg_wdata     = '0;
        send_hold     = 1'b0;
        hold_req      = 1'b0;
        fails         = 0;
        stim_count    = 0;
        results_ready = 1'b0;
        mdl_decrypt   = 1'b0;
        mdl_seed      = 32'd1;
        mdl_start     = 32'd0;
        mdl_count     = 13'd4096;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reads before any run, unknown command, pixel extremes
        push_cmd(CMD_READ, 12'd0, 24'h0);
        push_cmd(CMD_READ, 12'hFFF, 24'hFFFFFF);
        push_cmd(CMD_NONE, 12'hFFF, 24'hFFFFFF);
        configure(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd2);
        push_cmd(CMD_WRITE, 12'd0, 24'hFFFFFF);
        push_cmd(CMD_WRITE, 12'd1, 24'h000000);
        push_cmd(CMD_WRITE, 12'hFFF, 24'h5A5AA5);
        push_run(13'd2);
        push_cmd(CMD_READ, 12'd0, 24'h0);
        push_cmd(CMD_READ, 12'd1, 24'h0);
        push_cmd(CMD_WRITE, 12'd1, 24'h123456);
        push_cmd(CMD_READ, 12'd1, 24'h0);
        // zero seed, count zero acting as one, decrypt
        configure(1'b1, 32'h0, 32'h0, 13'd0);
        push_run(13'd0);
        push_cmd(CMD_READ, 12'd0, 24'h0);
        push_cmd(CMD_READ, 12'd1, 24'h0);
        configure(1'b1, 32'hFFFF_FFFF, 32'h8000_0001, 13'd1);
        push_run(13'd1);
        push_cmd(CMD_READ, 12'd0, 24'h0);

        // one larger image, then a small one with a long output stall
        image_pass(1'b0, $urandom, $urandom, 13'd300, 40, 1'b0);
        image_pass(1'b1, $urandom, $urandom, 13'd8, 90, 1'b1);

        while (stim_count < 1750)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                count = 13'd0;
            else if (k == 1)
                count = 13'd1;
            else
                count = 13'($urandom_range(2, 48));
            image_pass(1'($urandom_range(0, 1)), key_value(), key_value(), count,
                       $urandom_range(4, 60), 1'b0);
        end

        wait_idle();
        if (fails == 0)
            $display("image_permute_xor_chain_cipher test passed");
        else
            $display("image_permute_xor_chain_cipher test failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("image_permute_xor_chain_cipher test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/ipxc_pkg.sv
design/image_permute_xor_chain_cipher.sv
dv/testbench.sv
